/* rtl/vsc_pkg.sv */
package vsc_pkg;

  localparam int NUM_LEVELS = 5;
  localparam int LEVEL_W    = 3;
  localparam int LED_W      = 5;
  localparam int PHASE_W    = 5;
  localparam int TIMEOUT_W  = 16;
  localparam int ADC_W      = 8;
  localparam int STORED_W   = 8;
  localparam int WIN_W      = 9;

  localparam logic [LEVEL_W-1:0]   LEVEL_FIRST      = 3'd0;
  localparam logic [LEVEL_W-1:0]   LEVEL_LAST       = 3'd4;
  localparam logic [PHASE_W-1:0]   PHASE_LAST       = 5'd19;
  localparam logic [PHASE_W-1:0]   PHASE_FAST_BLINK = 5'd10;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET    = 16'd300;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_TICK  = 1'b1;
  localparam logic KEY_DOWN  = 1'b0;
  localparam logic KEY_UP    = 1'b1;

  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [LED_W-1:0]   led_t;

  typedef struct packed {
    logic                action;
    logic                key_level;
    logic [ADC_W-1:0]    adc_sample;
    logic [STORED_W-1:0] stored_level;
  } item_t;

  typedef struct packed {
    logic [2:0] cfg_pins;
    led_t       led_mask;
    logic       out_of_window;
    level_t     level_now;
    logic       in_change_mode;
    logic       save_request;
    logic       flash_all;
  } result_t;

  function automatic logic [2:0] pin_code(input level_t lvl);
    logic [2:0] code;
    case (lvl)
      3'd0: code = 3'd1;
      3'd1: code = 3'd0;
      3'd2: code = 3'd4;
      3'd3: code = 3'd6;
      3'd4: code = 3'd2;
      default: code = 3'd0;
    endcase
    return code;
  endfunction

  function automatic logic [WIN_W-1:0] win_lo(input level_t lvl);
    logic [WIN_W-1:0] lo;
    case (lvl)
      3'd0: lo = 9'd57;
      3'd1: lo = 9'd108;
      3'd2: lo = 9'd146;
      3'd3: lo = 9'd184;
      3'd4: lo = 9'd247;
      default: lo = 9'd0;
    endcase
    return lo;
  endfunction

  function automatic logic [WIN_W-1:0] win_hi(input level_t lvl);
    logic [WIN_W-1:0] hi;
    case (lvl)
      3'd0: hi = 9'd69;
      3'd1: hi = 9'd120;
      3'd2: hi = 9'd158;
      3'd3: hi = 9'd197;
      3'd4: hi = 9'd260;
      default: hi = 9'd0;
    endcase
    return hi;
  endfunction

  function automatic led_t level_mask(input level_t lvl);
    return led_t'(1) << lvl;
  endfunction

endpackage

/* rtl/vsc_in_stage.sv */
module vsc_in_stage
  import vsc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  item_t item_in,
  input  logic  advance,
  output logic  item_valid,
  output item_t item_q
);

  assign in_stall = item_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_q <= item_in;
    end
  end

endmodule

/* rtl/vsc_core.sv */
module vsc_core
  import vsc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  item_t                item,
  input  logic [TIMEOUT_W-1:0] change_timeout,
  output result_t              res
);

  level_t               selected_level;
  logic                 last_key;
  logic                 change_enabled;
  logic [TIMEOUT_W-1:0] idle_ticks;
  logic [PHASE_W-1:0]   blink_phase;
  level_t               blink_target;
  led_t                 led_bits;

  level_t               selected_level_next;
  logic                 last_key_next;
  logic                 change_enabled_next;
  logic [TIMEOUT_W-1:0] idle_ticks_next;
  logic [PHASE_W-1:0]   blink_phase_next;
  logic                 blinking;
  level_t               blink_target_next;
  led_t                 led_bits_next;

  logic                 is_start;
  logic                 press;
  logic                 in_win;
  logic [WIN_W-1:0]     adc_ext;
  logic [TIMEOUT_W-1:0] idle_inc;
  logic                 blink_due;
  led_t                 led_base;
  led_t                 led_win;
  logic                 save;
  logic                 flash;

  assign is_start = (item.action == ACT_START);
  assign press    = !is_start && change_enabled && (last_key == KEY_UP)
                    && (item.key_level == KEY_DOWN);
  assign adc_ext  = {1'b0, item.adc_sample};

  // level after load or key press
  always_comb begin
    if (is_start) begin
      if (item.stored_level < STORED_W'(NUM_LEVELS)) begin
        selected_level_next = item.stored_level[LEVEL_W-1:0];
      end else begin
        selected_level_next = LEVEL_FIRST;
      end
    end else if (press) begin
      if (selected_level == LEVEL_LAST) begin
        selected_level_next = LEVEL_FIRST;
      end else begin
        selected_level_next = selected_level + 3'd1;
      end
    end else begin
      selected_level_next = selected_level;
    end
  end

  assign in_win = (adc_ext >= win_lo(selected_level_next))
                  && (adc_ext <= win_hi(selected_level_next));

  always_comb begin
    if (is_start) begin
      led_base = '0;
    end else if (press) begin
      led_base = led_bits & ~level_mask(selected_level);
    end else begin
      led_base = led_bits;
    end
  end

  assign led_win  = in_win ? (led_base | level_mask(selected_level_next)) : led_base;
  assign blinking = !in_win;

  always_comb begin
    if (!in_win) begin
      blink_target_next = selected_level_next;
    end else if (is_start) begin
      blink_target_next = LEVEL_FIRST;
    end else begin
      blink_target_next = blink_target;
    end
  end

  assign blink_due = (blink_phase == '0)
                     || (change_enabled && (blink_phase == PHASE_FAST_BLINK));
  assign idle_inc  = (press ? '0 : idle_ticks) + 16'd1;

  always_comb begin
    save                = 1'b0;
    flash               = 1'b0;
    last_key_next       = item.key_level;
    change_enabled_next = change_enabled;
    idle_ticks_next     = idle_ticks;
    led_bits_next       = led_win;
    blink_phase_next    = (blink_phase == PHASE_LAST) ? '0 : blink_phase + 5'd1;
    if (is_start) begin
      change_enabled_next = (item.key_level == KEY_DOWN);
      last_key_next       = KEY_UP;
      idle_ticks_next     = '0;
      blink_phase_next    = '0;
      save                = (item.stored_level >= STORED_W'(NUM_LEVELS));
    end else begin
      if (blink_due && blinking) begin
        led_bits_next = led_win ^ level_mask(blink_target_next);
      end
      if (change_enabled) begin
        idle_ticks_next = idle_inc;
        if (idle_inc >= change_timeout) begin
          change_enabled_next = 1'b0;
          save                = 1'b1;
          flash               = 1'b1;
          led_bits_next       = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      selected_level <= LEVEL_FIRST;
      last_key       <= KEY_UP;
      change_enabled <= 1'b0;
      idle_ticks     <= '0;
      blink_phase    <= '0;
      blink_target   <= LEVEL_FIRST;
      led_bits       <= '0;
    end else if (fire) begin
      selected_level <= selected_level_next;
      last_key       <= last_key_next;
      change_enabled <= change_enabled_next;
      idle_ticks     <= idle_ticks_next;
      blink_phase    <= blink_phase_next;
      blink_target   <= blink_target_next;
      led_bits       <= led_bits_next;
    end
  end

  assign res.cfg_pins       = pin_code(selected_level_next);
  assign res.led_mask       = led_bits_next;
  assign res.out_of_window  = !in_win;
  assign res.level_now      = selected_level_next;
  assign res.in_change_mode = change_enabled_next;
  assign res.save_request   = save;
  assign res.flash_all      = flash;

endmodule

/* rtl/vsc_out_stage.sv */
module vsc_out_stage
  import vsc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  result_t res_in,
  input  logic    out_stall,
  output logic    advance,
  output logic    out_valid,
  output result_t res_q
);

  assign advance = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= res_in;
    end
  end

endmodule

/* rtl/pd_voltage_select_controller_top.sv */
// five-level charger voltage selector: each start or tick request passes an input register,
// combinational compare and counter logic against the level/blink/timeout state, and a
// result register, so one request is taken every clock unless out_stall holds the result;
// the state update in that single logic stage sets the rate. The user must write
// change_timeout via cfg only while no request is in flight; the block does not enforce it.
module pd_voltage_select_controller_top
  import vsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  action,
  input  logic                  key_level,
  input  logic [ADC_W-1:0]      adc_sample,
  input  logic [STORED_W-1:0]   stored_level,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            cfg_pins,
  output logic [LED_W-1:0]      led_mask,
  output logic                  out_of_window,
  output logic [LEVEL_W-1:0]    level_now,
  output logic                  in_change_mode,
  output logic                  save_request,
  output logic                  flash_all,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [TIMEOUT_W-1:0]  cfg_data
);

  logic [TIMEOUT_W-1:0] change_timeout;
  item_t                item_in;
  item_t                item_q;
  logic                 item_valid;
  logic                 advance;
  logic                 fire;
  result_t              res;
  result_t              res_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      change_timeout <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      change_timeout <= cfg_data;
    end
  end

  assign item_in.action       = action;
  assign item_in.key_level    = key_level;
  assign item_in.adc_sample   = adc_sample;
  assign item_in.stored_level = stored_level;

  assign fire = item_valid && advance;

  vsc_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .item_in    (item_in),
    .advance    (advance),
    .item_valid (item_valid),
    .item_q     (item_q)
  );

  vsc_core u_core (
    .clk            (clk),
    .rst            (rst),
    .fire           (fire),
    .item           (item_q),
    .change_timeout (change_timeout),
    .res            (res)
  );

  vsc_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .res_in    (res),
    .out_stall (out_stall),
    .advance   (advance),
    .out_valid (out_valid),
    .res_q     (res_q)
  );

  assign cfg_pins       = res_q.cfg_pins;
  assign led_mask       = res_q.led_mask;
  assign out_of_window  = res_q.out_of_window;
  assign level_now      = res_q.level_now;
  assign in_change_mode = res_q.in_change_mode;
  assign save_request   = res_q.save_request;
  assign flash_all      = res_q.flash_all;

`ifndef SYNTHESIS
  a_flash_ends_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && flash_all |-> save_request && !in_change_mode && (led_mask == '0))
    else $error("flash without save or with change mode still on");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (level_now <= LEVEL_LAST))
    else $error("selected level out of range");

  a_in_window_led: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_of_window && !flash_all |-> led_mask[level_now])
    else $error("level led dark while sample in window");

  a_no_fire_on_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !fire)
    else $error("result register overwritten while held");
`endif

endmodule
